FILE: hw/rtl/scl_pkg.sv
// shared constants, register indexes and divider request types for the compressor/limiter
`timescale 1ns / 1ps

package scl_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int LEVEL_W     = 32;

    localparam int THR_W      = 24;
    localparam int RATIO_W    = 22;
    localparam int MAKEUP_W   = 23;
    localparam int ATTACK_W   = 17;
    localparam int RELEASE_W  = 25;
    localparam int LIMIT_W    = 25;
    localparam int CFG_DATA_W = 25;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RATIO     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAKEUP    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ATTACK    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RELEASE   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_FULL_MODE = 3'd6;

    localparam logic [THR_W-1:0]     THR_RST     = 24'd838861;
    localparam logic [MAKEUP_W-1:0]  MAKEUP_RST  = 23'd65536;
    localparam logic [ATTACK_W-1:0]  ATTACK_RST  = 17'd65536;
    localparam logic [RELEASE_W-1:0] RELEASE_RST = 25'd16646144;

    // stream payload widths, rounded up to whole bytes
    localparam int DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    // gain is signed Q16, saturated to +-(2^31-1)
    localparam int GAIN_W = 32;
    localparam logic signed [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};

    // shared multiplier
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // shared divider: numerator makeup*thr*2^16, denominator magnitude
    localparam int NUM_W = MAKEUP_W + THR_W + 16;
    localparam int DEN_W = RATIO_W + LEVEL_W;
    localparam int QUO_W = GAIN_W - 1;
    localparam int CNT_W = $clog2(QUO_W);

    // limiter ceiling: register value or 1000.0 in level units
    localparam int LIMV_W  = SAMPLE_BITS + 9;
    localparam int LIM16_W = LIMV_W + 16;
    localparam logic [LIMV_W-1:0] NOLIMIT_LEVEL = LIMV_W'(64'd1000 << (SAMPLE_BITS - 1));

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

endpackage

FILE: hw/rtl/scl_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module scl_mul (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [scl_pkg::MUL_W-1:0]  opa,
    input  logic signed [scl_pkg::MUL_W-1:0]  opb,
    output logic signed [scl_pkg::PROD_W-1:0] prod
);
    import scl_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= opa * opb;
        end
    end

    assign prod = prod_reg;

endmodule

FILE: hw/rtl/scl_div.sv
// shared restoring divider, one quotient bit per cycle, with overflow detect
`timescale 1ns / 1ps

module scl_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  scl_pkg::div_req_t   req,
    output scl_pkg::div_rsp_t   rsp
);
    import scl_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic                 ovf_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [QUO_W-1:0]     nq_reg;

    logic [NUM_W-QUO_W-1:0] num_hi;
    logic                   ovf_c;
    logic [DEN_W:0]         trial;
    logic [DEN_W:0]         diff;
    logic                   ge;

    assign num_hi = req.num[NUM_W-1:QUO_W];
    // quotient would not fit in QUO_W bits
    assign ovf_c  = DEN_W'(num_hi) >= req.den;
    assign trial  = {rem_reg, nq_reg[QUO_W-1]};
    assign diff   = trial - {1'b0, den_reg};
    assign ge     = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= !ovf_c;
                done_reg <= ovf_c;
            end else if (busy_reg && cnt_reg == CNT_W'(QUO_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            den_reg <= req.den;
            rem_reg <= DEN_W'(num_hi);
            nq_reg  <= req.num[QUO_W-1:0];
            ovf_reg <= ovf_c;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            nq_reg  <= {nq_reg[QUO_W-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign rsp.quo  = nq_reg;

endmodule

FILE: hw/rtl/stereo_peak_compressor_limiter_unit.sv
// stereo peak compressor/limiter: sequencer around a shared multiplier and divider
// it forms the envelope, peak hold, gain numerator and denominator, divides for the gain
// when needed, checks the limiter in full mode and divides for its cap when hit, then scales
// both samples; a new request is taken only in idle, once the previous result is handed on
// reset: synchronous active-low aresetn clears envelope, peak hold, registers to defaults
`timescale 1ns / 1ps

module stereo_peak_compressor_limiter_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [scl_pkg::DATA_W-1:0]        s_tdata,   // sample_left, sample_right
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [scl_pkg::DATA_W-1:0]        m_tdata,   // out_left, out_right
    output logic                              m_tuser,   // clipped
    input  logic                              cfg_wr_en,
    input  logic [scl_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [scl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import scl_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ENV  = 4'd1;
    localparam logic [3:0] ST_HOLD = 4'd2;
    localparam logic [3:0] ST_NUM  = 4'd3;
    localparam logic [3:0] ST_RAT  = 4'd4;
    localparam logic [3:0] ST_DEN  = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_LIM  = 4'd7;
    localparam logic [3:0] ST_LIMC = 4'd8;
    localparam logic [3:0] ST_LIMD = 4'd9;
    localparam logic [3:0] ST_OUTL = 4'd10;
    localparam logic [3:0] ST_OUTR = 4'd11;
    localparam logic [3:0] ST_SEND = 4'd12;

    localparam logic signed [PROD_W-1:0] SMAX =
        $signed({{(PROD_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [PROD_W-1:0] SMIN =
        $signed({{(PROD_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}});

    // configuration
    logic [THR_W-1:0]            thr_reg;
    logic signed [RATIO_W-1:0]   ratio_reg;
    logic [MAKEUP_W-1:0]         makeup_reg;
    logic [ATTACK_W-1:0]         attack_reg;
    logic [RELEASE_W-1:0]        release_reg;
    logic [LIMIT_W-1:0]          limit_reg;
    logic                        full_reg;

    // control and state
    logic [3:0]                  state_reg;
    logic [LEVEL_W-1:0]          env_reg;
    logic [LEVEL_W-1:0]          hold_reg;
    logic                        m_tvalid_reg;

    // payload
    logic signed [SAMPLE_BITS-1:0] left_reg;
    logic signed [SAMPLE_BITS-1:0] right_reg;
    logic [SAMPLE_BITS-1:0]        peak_reg;
    logic signed [GAIN_W-1:0]      gain_reg;
    logic [NUM_W-1:0]              num_reg;
    logic                          den_neg_reg;
    logic [SAMPLE_BITS-1:0]        outl_reg;
    logic                          clipl_reg;
    logic [DATA_W-1:0]             m_tdata_reg;
    logic                          m_tuser_reg;

    // shared units
    logic                          mul_en;
    logic signed [MUL_W-1:0]       mul_a;
    logic signed [MUL_W-1:0]       mul_b;
    logic signed [PROD_W-1:0]      prod;
    div_req_t                      div_req;
    div_rsp_t                      div_rsp;

    // combinational helpers
    logic signed [SAMPLE_BITS-1:0] in_left;
    logic signed [SAMPLE_BITS-1:0] in_right;
    logic [SAMPLE_BITS-1:0]        abs_left;
    logic [SAMPLE_BITS-1:0]        abs_right;
    logic [THR_W-1:0]              thr_eff;
    logic [LEVEL_W-1:0]            thr_ext;
    logic [LEVEL_W-1:0]            peak_ext;
    logic                          rise;
    logic                          compress;
    logic [LEVEL_W:0]              env_att;
    logic [LEVEL_W-1:0]            env_new;
    logic [LEVEL_W-1:0]            hold_dec;
    logic signed [DEN_W:0]         den_c;
    logic [DEN_W:0]                den_abs;
    logic signed [GAIN_W-1:0]      gain_pos;
    logic [LIMV_W-1:0]             lim_eff;
    logic [LIM16_W-1:0]            lim16;
    logic                          limit_hit;
    logic [SAMPLE_BITS:0]          sat_out;
    logic signed [GAIN_W-1:0]      quo_gain;

    function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W:0] v);
        return v[LEVEL_W] ? {LEVEL_W{1'b1}} : v[LEVEL_W-1:0];
    endfunction

    // floor(p / 2^16) saturated to the sample range; clip flag in the top bit
    function automatic logic [SAMPLE_BITS:0] sat_sample(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] sh;
        sh = p >>> 16;
        if (sh > SMAX) begin
            return {1'b1, SMAX[SAMPLE_BITS-1:0]};
        end else if (sh < SMIN) begin
            return {1'b1, SMIN[SAMPLE_BITS-1:0]};
        end else begin
            return {1'b0, sh[SAMPLE_BITS-1:0]};
        end
    endfunction

    assign in_left   = s_tdata[SAMPLE_BITS-1:0];
    assign in_right  = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign abs_left  = in_left[SAMPLE_BITS-1] ? -in_left : in_left;
    assign abs_right = in_right[SAMPLE_BITS-1] ? -in_right : in_right;

    assign thr_eff   = (thr_reg == '0) ? THR_W'(1) : thr_reg;
    assign thr_ext   = LEVEL_W'(thr_eff);
    assign peak_ext  = LEVEL_W'(peak_reg);
    assign rise      = peak_ext > env_reg;
    assign compress  = env_reg > thr_ext;

    assign env_att   = {1'b0, env_reg} + prod[16 +: LEVEL_W+1];
    assign env_new   = rise ? sat_level(env_att) : sat_level(prod[24 +: LEVEL_W+1]);
    assign hold_dec  = sat_level(prod[24 +: LEVEL_W+1]);

    // denominator thr*2^16 + ratio*(env-thr)
    assign den_c     = $signed((DEN_W+1)'({thr_eff, 16'b0})) + $signed(prod[DEN_W:0]);
    assign den_abs   = den_c[DEN_W] ? -den_c : den_c;

    assign gain_pos  = gain_reg[GAIN_W-1] ? '0 : gain_reg;
    assign lim_eff   = (limit_reg == '0) ? NOLIMIT_LEVEL : LIMV_W'(limit_reg);
    assign lim16     = {lim_eff, 16'b0};
    assign limit_hit = $unsigned(prod) > PROD_W'(lim16);
    assign sat_out   = sat_sample(prod);
    assign quo_gain  = $signed({1'b0, div_rsp.quo});

    // operand select for the shared multiplier
    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            ST_ENV: begin
                mul_en = 1'b1;
                if (rise) begin
                    mul_a = $signed(MUL_W'(attack_reg));
                    mul_b = $signed(MUL_W'(peak_ext - env_reg));
                end else begin
                    mul_a = $signed(MUL_W'(env_reg));
                    mul_b = $signed(MUL_W'(release_reg));
                end
            end
            ST_HOLD: begin
                mul_en = 1'b1;
                mul_a  = $signed(MUL_W'(hold_reg));
                mul_b  = $signed(MUL_W'(release_reg));
            end
            ST_NUM: begin
                mul_en = 1'b1;
                mul_a  = $signed(MUL_W'(makeup_reg));
                mul_b  = $signed(MUL_W'(thr_eff));
            end
            ST_RAT: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(ratio_reg);
                mul_b  = $signed(MUL_W'(env_reg - thr_ext));
            end
            ST_LIM: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(gain_pos);
                mul_b  = $signed(MUL_W'(hold_reg));
            end
            ST_OUTL: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(left_reg);
                mul_b  = MUL_W'(gain_reg);
            end
            ST_OUTR: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(right_reg);
                mul_b  = MUL_W'(gain_reg);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // divider requests: gain quotient, then limiter cap
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = num_reg;
        div_req.den   = den_abs[DEN_W-1:0];
        if (state_reg == ST_DEN) begin
            div_req.start = compress && (den_c != '0);
        end else if (state_reg == ST_LIMC) begin
            div_req.start = limit_hit;
            div_req.num   = NUM_W'(lim16);
            div_req.den   = DEN_W'(hold_reg);
        end
    end

    scl_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .opa  (mul_a),
        .opb  (mul_b),
        .prod (prod)
    );

    scl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // control, configuration and level state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg      <= THR_RST;
            ratio_reg    <= '0;
            makeup_reg   <= MAKEUP_RST;
            attack_reg   <= ATTACK_RST;
            release_reg  <= RELEASE_RST;
            limit_reg    <= '0;
            full_reg     <= 1'b0;
            state_reg    <= ST_IDLE;
            env_reg      <= '0;
            hold_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_THRESHOLD: thr_reg     <= cfg_wdata[THR_W-1:0];
                    REG_RATIO:     ratio_reg   <= $signed(cfg_wdata[RATIO_W-1:0]);
                    REG_MAKEUP:    makeup_reg  <= cfg_wdata[MAKEUP_W-1:0];
                    REG_ATTACK:    attack_reg  <= cfg_wdata[ATTACK_W-1:0];
                    REG_RELEASE:   release_reg <= cfg_wdata[RELEASE_W-1:0];
                    REG_LIMIT:     limit_reg   <= cfg_wdata[LIMIT_W-1:0];
                    REG_FULL_MODE: full_reg    <= cfg_wdata[0];
                    default:       ;
                endcase
            end

            // a new result may replace the one leaving in the same cycle
            if (state_reg == ST_SEND && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_ENV;
                    end
                end
                ST_ENV:  state_reg <= ST_HOLD;
                ST_HOLD: begin
                    env_reg   <= env_new;
                    state_reg <= ST_NUM;
                end
                ST_NUM: begin
                    if (full_reg) begin
                        hold_reg <= rise ? peak_ext : hold_dec;
                    end
                    state_reg <= ST_RAT;
                end
                ST_RAT:  state_reg <= ST_DEN;
                ST_DEN: begin
                    state_reg <= div_req.start ? ST_DIV : ST_LIM;
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        state_reg <= ST_LIM;
                    end
                end
                ST_LIM: begin
                    state_reg <= full_reg ? ST_LIMC : ST_OUTL;
                end
                ST_LIMC: begin
                    state_reg <= limit_hit ? ST_LIMD : ST_OUTL;
                end
                ST_LIMD: begin
                    if (div_rsp.done) begin
                        state_reg <= ST_OUTL;
                    end
                end
                ST_OUTL: state_reg <= ST_OUTR;
                ST_OUTR: state_reg <= ST_SEND;
                ST_SEND: begin
                    if (!m_tvalid_reg || m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                left_reg  <= in_left;
                right_reg <= in_right;
                peak_reg  <= (abs_right > abs_left) ? abs_right : abs_left;
            end
            ST_RAT: begin
                num_reg <= {prod[NUM_W-17:0], 16'b0};
            end
            ST_DEN: begin
                den_neg_reg <= den_c[DEN_W];
                if (!compress) begin
                    gain_reg <= $signed(GAIN_W'(makeup_reg));
                end else if (den_c == '0) begin
                    gain_reg <= (makeup_reg != '0) ? GAIN_MAX : '0;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    if (den_neg_reg) begin
                        gain_reg <= div_rsp.ovf ? -GAIN_MAX : -quo_gain;
                    end else begin
                        gain_reg <= div_rsp.ovf ? GAIN_MAX : quo_gain;
                    end
                end
            end
            ST_LIM: begin
                if (full_reg) begin
                    gain_reg <= gain_pos;
                end
            end
            ST_LIMD: begin
                if (div_rsp.done) begin
                    gain_reg <= quo_gain;
                end
            end
            ST_OUTR: begin
                outl_reg  <= sat_out[SAMPLE_BITS-1:0];
                clipl_reg <= sat_out[SAMPLE_BITS];
            end
            ST_SEND: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_reg <= DATA_W'({sat_out[SAMPLE_BITS-1:0], outl_reg});
                    m_tuser_reg <= clipl_reg | sat_out[SAMPLE_BITS];
                end
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: verif/tb.sv
// self-checking stream testbench for the stereo peak compressor/limiter
`timescale 1ns / 1ps

module tb;
    import scl_pkg::*;

    localparam int     PHASES      = 12;
    localparam int     PHASE_PAIRS = 162;
    localparam int     LONG_HOLD   = 600;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam longint LEVEL_TOP   = 64'hFFFF_FFFF;
    localparam longint GAIN_TOP    = longint'(GAIN_MAX);
    localparam longint SMAX        = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SMIN        = -SMAX - 1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] out_left;
        logic [SAMPLE_BITS-1:0] out_right;
        logic                   clipped;
    } stereo_out_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_W-1:0]     m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // register copies, as the block holds them
    logic [THR_W-1:0]            thr_reg     = THR_RST;
    logic signed [RATIO_W-1:0]   ratio_reg   = '0;
    logic [MAKEUP_W-1:0]         makeup_reg  = MAKEUP_RST;
    logic [ATTACK_W-1:0]         attack_reg  = ATTACK_RST;
    logic [RELEASE_W-1:0]        keep_reg    = RELEASE_RST;
    logic [LIMIT_W-1:0]          limit_reg   = '0;
    logic                        full_reg    = 1'b0;

    longint env_level  = 0;
    longint hold_level = 0;

    logic [DATA_W-1:0] pending_pairs[$];
    stereo_out_t       expected_pairs[$];

    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    logic   hold_req       = 1'b0;
    logic   hold_done      = 1'b0;
    int     hold_cnt       = 0;
    int     fail_cnt       = 0;
    int     sent_cnt       = 0;
    int     result_cnt     = 0;
    int     clip_cnt       = 0;
    longint cycle_cnt      = 0;

    stereo_peak_compressor_limiter_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint release_step(input longint level);
        longint v;
        v = (level * longint'(keep_reg)) >>> 24;
        return (v > LEVEL_TOP) ? LEVEL_TOP : v;
    endfunction

    // level follower, gain computer and limiter for one stereo pair
    function automatic stereo_out_t compress_pair(input logic [SAMPLE_BITS-1:0] left_in,
                                                  input logic [SAMPLE_BITS-1:0] right_in);
        longint      a, b, pa, pb, peak, thr, num, den, q, gain, lim, cap;
        longint      res[2];
        int          k;
        stereo_out_t o;
        a    = longint'($signed(left_in));
        b    = longint'($signed(right_in));
        pa   = (a < 0) ? -a : a;
        pb   = (b < 0) ? -b : b;
        peak = (pb > pa) ? pb : pa;
        thr  = (thr_reg == 0) ? 1 : longint'(thr_reg);

        if (peak > env_level) begin
            env_level = env_level + ((longint'(attack_reg) * (peak - env_level)) >>> 16);
            if (env_level > LEVEL_TOP) env_level = LEVEL_TOP;
        end else begin
            env_level = release_step(env_level);
        end
        if (full_reg) hold_level = (peak > env_level) ? peak : release_step(hold_level);

        if (env_level > thr) begin
            num = longint'(makeup_reg) * thr * 65536;
            den = thr * 65536 + longint'(ratio_reg) * (env_level - thr);
            if (den > 0) begin
                q    = num / den;
                gain = (q > GAIN_TOP) ? GAIN_TOP : q;
            end else if (den < 0) begin
                q    = num / (-den);
                gain = (q > GAIN_TOP) ? -GAIN_TOP : -q;
            end else begin
                gain = (num != 0) ? GAIN_TOP : 0;
            end
        end else begin
            gain = longint'(makeup_reg);
        end

        if (full_reg) begin
            // a zero limit register means a ceiling of 1000.0
            lim = (limit_reg != 0) ? longint'(limit_reg) : (longint'(1000) << (SAMPLE_BITS - 1));
            if (gain < 0) gain = 0;
            if (hold_level != 0) begin
                cap = (lim << 16) / hold_level;
                if (gain > cap) gain = cap;
            end
        end

        res[0]    = (a * gain) >>> 16;
        res[1]    = (b * gain) >>> 16;
        o.clipped = 1'b0;
        for (k = 0; k < 2; k++) begin
            if (res[k] > SMAX) begin
                res[k]    = SMAX;
                o.clipped = 1'b1;
            end
            if (res[k] < SMIN) begin
                res[k]    = SMIN;
                o.clipped = 1'b1;
            end
        end
        o.out_left  = SAMPLE_BITS'(res[0]);
        o.out_right = SAMPLE_BITS'(res[1]);
        return o;
    endfunction

    // random upper bits ride along above each register's width
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input longint value);
        logic [CFG_DATA_W-1:0] junk;
        logic [CFG_DATA_W-1:0] mask;
        int                    w;
        junk = CFG_DATA_W'($urandom);
        case (idx)
            REG_THRESHOLD: w = THR_W;
            REG_RATIO:     w = RATIO_W;
            REG_MAKEUP:    w = MAKEUP_W;
            REG_ATTACK:    w = ATTACK_W;
            REG_RELEASE:   w = RELEASE_W;
            REG_LIMIT:     w = LIMIT_W;
            default:       w = 1;
        endcase
        mask = CFG_DATA_W'((longint'(1) << w) - 1);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= (junk & ~mask) | (CFG_DATA_W'(value) & mask);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_THRESHOLD: thr_reg    = THR_W'(value);
            REG_RATIO:     ratio_reg  = RATIO_W'(value);
            REG_MAKEUP:    makeup_reg = MAKEUP_W'(value);
            REG_ATTACK:    attack_reg = ATTACK_W'(value);
            REG_RELEASE:   keep_reg   = RELEASE_W'(value);
            REG_LIMIT:     limit_reg  = LIMIT_W'(value);
            default:       full_reg   = value[0];
        endcase
        @(negedge aclk);
    endtask

    task automatic load_settings(input longint thr, input longint ratio, input longint makeup,
                                 input longint attack, input longint keep,
                                 input longint limit, input longint full);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_RATIO, ratio);
        write_reg(REG_MAKEUP, makeup);
        write_reg(REG_ATTACK, attack);
        write_reg(REG_RELEASE, keep);
        write_reg(REG_LIMIT, limit);
        write_reg(REG_FULL_MODE, full);
    endtask

    task automatic offer(input longint left, input longint right);
        pending_pairs.push_back({SAMPLE_BITS'(right), SAMPLE_BITS'(left)});
    endtask

    // every request has one result, so the block is idle once nothing is owed
    task automatic drain();
        @(negedge aclk);
        while (pending_pairs.size() != 0 || s_tvalid || expected_pairs.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    function automatic longint rand_sample(input int shift);
        logic signed [SAMPLE_BITS-1:0] v;
        v = SAMPLE_BITS'($urandom);
        case ($urandom_range(0, 15))
            0:       v = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            1:       v = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            2:       v = '0;
            default: v = v >>> shift;
        endcase
        return longint'(v);
    endfunction

    // request side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_pairs.push_back(compress_pair(s_tdata[SAMPLE_BITS-1:0],
                                                       s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
                sent_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_pairs.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // one long back-pressure stretch so the block fills and stalls its input
    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == LONG_HOLD - 1) hold_done <= 1'b1;
        end
    end

    // result side
    always @(posedge aclk) begin
        stereo_out_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                result_cnt++;
                if (m_tuser) clip_cnt++;
                if (expected_pairs.size() == 0) begin
                    $error("result with no request outstanding: %h", m_tdata);
                    fail_cnt++;
                end else begin
                    want = expected_pairs.pop_front();
                    if (m_tdata[SAMPLE_BITS-1:0] !== want.out_left) begin
                        $error("out_left: expected %0d, got %0d", $signed(want.out_left),
                               $signed(m_tdata[SAMPLE_BITS-1:0]));
                        fail_cnt++;
                    end
                    if (m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] !== want.out_right) begin
                        $error("out_right: expected %0d, got %0d", $signed(want.out_right),
                               $signed(m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
                        fail_cnt++;
                    end
                    if (m_tuser !== want.clipped) begin
                        $error("clipped: expected %0d, got %0d", want.clipped, m_tuser);
                        fail_cnt++;
                    end
                end
            end
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("run timed out after %0d cycles", cycle_cnt);
            $display("stereo_peak_compressor_limiter_unit: mismatch");
            $finish;
        end
    end

    initial begin
        int     ph, i, mode, amp_shift;
        longint l, r;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: sample extremes and alternating bit patterns
        offer(SMIN, SMAX);
        offer(SMAX, SMIN);
        offer(0, 0);
        offer(longint'($signed(24'h555555)), longint'($signed(24'hAAAAAA)));
        offer(longint'($signed(24'hAAAAAA)), longint'($signed(24'h555555)));
        offer(1, -1);
        drain();

        // ratio of -1: envelope at twice the threshold zeroes the divisor, above it flips sign
        load_settings(1 << 21, -65536, 65536, 65536, 0, 0, 0);
        offer(1 << 22, -5);
        offer(0, 0);
        offer(SMIN, 100);
        offer(0, 0);
        drain();
        write_reg(REG_MAKEUP, 0);
        offer(1 << 22, 7);
        drain();

        // zero threshold register behaves as one
        load_settings(0, 65536, 65536, 65536, 0, 0, 0);
        offer(1000, -3000);
        drain();

        // full mode: negative gain clamped, zero hold, then the limiter cutting in
        load_settings(1 << 21, -65536, 65536, 65536, 0, 1 << 22, 1);
        offer(SMAX, SMIN);
        offer(0, 0);
        offer(1 << 20, -(1 << 19));
        drain();
        write_reg(REG_ATTACK, 0);
        offer(SMAX, 1 << 22);
        offer(-(1 << 21), 12345);
        drain();
        write_reg(REG_LIMIT, 0);
        write_reg(REG_MAKEUP, 6553600);
        offer(SMAX, SMIN);
        offer(-77, 4096);
        drain();

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: load_settings(1 << 23, 1114112, 6553600, 65536, 1 << 24, 25165824, 1);
                1: load_settings(1, -65536, 0, 0, 0, 0, 0);
                2: load_settings(24'hFFFFFF, -1, 23'h7FFFFF, 17'h1FFFF, 25'h1FFFFFF,
                                 25'h1FFFFFF, 1);
                default: load_settings(
                    ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1 << 23),
                    longint'($urandom_range(0, 1179648)) - 65536,
                    $urandom_range(0, 1) ? $urandom_range(0, 6553600)
                                         : $urandom_range(16384, 262144),
                    $urandom_range(0, 65536),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1 << 24)
                                                : (1 << 24) - $urandom_range(0, 1 << 18),
                    ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25165824),
                    $urandom_range(0, 1));
            endcase
            mode = ph % 4;
            send_idle_pct  = (mode == 1) ? 59 : (mode == 3) ? 15 : 0;
            recv_stall_pct = (mode == 2) ? 59 : (mode == 3) ? 15 : 0;
            // amplitude moves in steps so the envelope settles and then swings
            amp_shift = 0;
            for (i = 0; i < PHASE_PAIRS; i++) begin
                if (i % 24 == 0) amp_shift = $urandom_range(0, 14);
                l = rand_sample(amp_shift);
                r = rand_sample(amp_shift);
                offer(l, r);
            end
            if (ph == 4) hold_req = 1'b1;
            drain();
        end

        repeat (80) @(negedge aclk);
        $display("%0d stereo requests over %0d register settings, %0d results, %0d clipped",
                 sent_cnt, PHASES + 7, result_cnt, clip_cnt);
        $display("covered extremes, zero and negative divisors, clamp, hold and limiter paths");
        if (fail_cnt == 0 && expected_pairs.size() == 0) begin
            $display("stereo_peak_compressor_limiter_unit: match");
        end else begin
            $display("stereo_peak_compressor_limiter_unit: mismatch");
        end
        $finish;
    end

endmodule

FILE: stereo_peak_compressor_limiter_unit.f
hw/rtl/scl_pkg.sv
hw/rtl/scl_mul.sv
hw/rtl/scl_div.sv
hw/rtl/stereo_peak_compressor_limiter_unit.sv
verif/tb.sv
